@@ hw/rtl/rsl_pkg.sv @@
// Shared constants, types and status codes for the raw string literal lexer.
`timescale 1ns / 1ps

package rsl_pkg;

    // Largest opening hash count that is accepted
    localparam int MAX_HASHES = 15;
    localparam int HASH_W     = $clog2(MAX_HASHES + 1);

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPR   = 8'h52;
    localparam logic [7:0] CH_LOWR   = 8'h72;
    localparam logic [7:0] CH_LOWT   = 8'h74;
    localparam logic [7:0] CH_LOWN   = 8'h6E;
    localparam logic [7:0] CH_LOWF   = 8'h66;
    localparam logic [7:0] CH_LOWB   = 8'h62;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;

    // Status codes carried on the result word
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_CLOSED   = 3'd1;
    localparam logic [2:0] ST_NO_OPEN  = 3'd2;
    localparam logic [2:0] ST_UNCLOSED = 3'd3;
    localparam logic [2:0] ST_DANGLING = 3'd4;
    localparam logic [2:0] ST_TOO_MANY = 3'd5;

    // Character class flags from the decoder
    typedef struct packed {
        logic is_quote;
        logic is_hash;
        logic is_escape;   // backslash outside raw mode
        logic is_prefix;   // r or R
    } t_char_class;

endpackage

@@ hw/rtl/rsl_decode.sv @@
// Character classifier and escape mapper for the raw string literal lexer.
`timescale 1ns / 1ps

module rsl_decode (
    input  logic [7:0]          i_char,
    input  logic                i_raw_mode,
    output rsl_pkg::t_char_class o_class,
    output logic [7:0]          o_unescaped
);

    // Classify the byte
    always_comb begin
        o_class.is_quote  = (i_char == rsl_pkg::CH_QUOTE);
        o_class.is_hash   = (i_char == rsl_pkg::CH_HASH);
        o_class.is_escape = (i_char == rsl_pkg::CH_BSLASH) && !i_raw_mode;
        o_class.is_prefix = (i_char == rsl_pkg::CH_LOWR) || (i_char == rsl_pkg::CH_UPPR);
    end

    // Map escape letters to control codes, others pass through
    always_comb begin
        case (i_char)
            rsl_pkg::CH_LOWT: o_unescaped = rsl_pkg::CH_TAB;
            rsl_pkg::CH_LOWR: o_unescaped = rsl_pkg::CH_CR;
            rsl_pkg::CH_LOWN: o_unescaped = rsl_pkg::CH_LF;
            rsl_pkg::CH_LOWF: o_unescaped = rsl_pkg::CH_FF;
            rsl_pkg::CH_LOWB: o_unescaped = rsl_pkg::CH_BS;
            default:          o_unescaped = i_char;
        endcase
    end

endmodule

@@ hw/rtl/raw_string_literal_lexer_unit.sv @@
// Raw string literal lexer top level: lexer state, word sequencer, output register.
// Results: each result word of an accepted word is loaded into the output register
// when the slot is free. A word yields up to MAX_HASHES + 1 result words on a failed
//   closing match, counted out by the hash counter of the flush sequencer. A new word
//   waits for an idle sequencer, but not for the output register to drain.
// Reset: synchronous, active low; returns to idle awaiting a prefix, no result pending.
`timescale 1ns / 1ps

module raw_string_literal_lexer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_in_char,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic [2:0] o_status,
    output logic       o_last
);

    localparam int HW = rsl_pkg::HASH_W;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HASHES  = 3'd1,
        PH_BODY    = 3'd2,
        PH_ESCAPE  = 3'd3,
        PH_PENDING = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE  = 2'd0,
        SQ_QUOTE = 2'd1,
        SQ_HASH  = 2'd2,
        SQ_TAIL  = 2'd3
    } t_seq;

    // Lexer state
    t_phase          r_phase, n_phase;
    logic            r_raw_mode, n_raw_mode;
    logic [HW-1:0]   r_hash_goal, n_hash_goal;
    logic [HW-1:0]   r_hash_seen, n_hash_seen;

    // Sequencer state
    t_seq            r_seq, n_seq;
    logic [HW-1:0]   r_cnt, n_cnt;
    logic            r_tail_en, n_tail_en;
    logic            r_tail_chr, n_tail_chr;
    logic [7:0]      r_tail_byte, n_tail_byte;
    logic [2:0]      r_tail_status, n_tail_status;

    // Output register
    logic            r_o_valid, n_o_valid;
    logic [7:0]      r_o_char, n_o_char;
    logic            r_o_char_valid, n_o_char_valid;
    logic [2:0]      r_o_status, n_o_status;
    logic            r_o_last, n_o_last;

    rsl_pkg::t_char_class w_class;
    logic [7:0]           w_unesc;
    logic                 w_accept;
    logic                 w_slot_free;

    // Body byte outcome
    logic       b_tail_en;
    logic [2:0] b_status;
    t_phase     b_phase;
    logic       b_clear;

    // Plan for the accepted word
    t_phase        p_phase;
    logic          p_raw;
    logic [HW-1:0] p_goal;
    logic [HW-1:0] p_seen;
    logic          p_flush;
    logic          p_tail_en;
    logic          p_tail_chr;
    logic [7:0]    p_tail_byte;
    logic [2:0]    p_tail_status;
    logic          p_clear;

    logic [HW:0]   w_seen_inc;

    rsl_decode u_decode (
        .i_char      (i_in_char),
        .i_raw_mode  (r_raw_mode),
        .o_class     (w_class),
        .o_unescaped (w_unesc)
    );

    assign o_ready      = (r_seq == SQ_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_slot_free  = !r_o_valid || i_ready;
    assign w_seen_inc   = {1'b0, r_hash_seen} + {{HW{1'b0}}, 1'b1};

    assign o_valid      = r_o_valid;
    assign o_out_char   = r_o_char;
    assign o_char_valid = r_o_char_valid;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

    // Ordinary body byte: quote opens a closing match, backslash an escape
    always_comb begin
        b_tail_en = 1'b0;
        b_status  = rsl_pkg::ST_BUSY;
        b_phase   = PH_BODY;
        b_clear   = 1'b0;
        if (w_class.is_quote) begin
            if (r_hash_goal == '0) begin
                b_tail_en = 1'b1;
                b_status  = rsl_pkg::ST_CLOSED;
                b_clear   = 1'b1;
            end else begin
                b_phase = PH_PENDING;
            end
        end else if (w_class.is_escape) begin
            b_phase = PH_ESCAPE;
        end else begin
            b_tail_en = 1'b1;
        end
    end

    // Lexer step for one word
    always_comb begin
        p_phase       = r_phase;
        p_raw         = r_raw_mode;
        p_goal        = r_hash_goal;
        p_seen        = r_hash_seen;
        p_flush       = 1'b0;
        p_tail_en     = 1'b0;
        p_tail_chr    = 1'b0;
        p_tail_byte   = i_in_char;
        p_tail_status = rsl_pkg::ST_BUSY;
        p_clear       = 1'b0;
        if (i_kind) begin
            // end of input
            p_tail_en = 1'b1;
            p_clear   = 1'b1;
            case (r_phase)
                PH_BODY:    p_tail_status = rsl_pkg::ST_UNCLOSED;
                PH_ESCAPE:  p_tail_status = rsl_pkg::ST_DANGLING;
                PH_PENDING: begin
                    p_flush       = 1'b1;
                    p_tail_status = rsl_pkg::ST_UNCLOSED;
                end
                default:    p_tail_status = rsl_pkg::ST_NO_OPEN;
            endcase
        end else begin
            case (r_phase)
                PH_BODY: begin
                    p_phase       = b_phase;
                    p_seen        = '0;
                    p_tail_en     = b_tail_en;
                    p_tail_chr    = (b_status == rsl_pkg::ST_BUSY);
                    p_tail_status = b_status;
                    p_clear       = b_clear;
                end
                PH_ESCAPE: begin
                    p_phase     = PH_BODY;
                    p_tail_en   = 1'b1;
                    p_tail_chr  = 1'b1;
                    p_tail_byte = w_unesc;
                end
                PH_PENDING: begin
                    if (w_class.is_hash) begin
                        if (w_seen_inc >= {1'b0, r_hash_goal}) begin
                            p_tail_en     = 1'b1;
                            p_tail_status = rsl_pkg::ST_CLOSED;
                            p_clear       = 1'b1;
                        end else begin
                            p_seen = w_seen_inc[HW-1:0];
                        end
                    end else begin
                        // failed match: flush, then lex the byte as body text
                        p_flush       = 1'b1;
                        p_phase       = b_phase;
                        p_seen        = '0;
                        p_tail_en     = b_tail_en;
                        p_tail_chr    = (b_status == rsl_pkg::ST_BUSY);
                        p_tail_status = b_status;
                        p_clear       = b_clear;
                    end
                end
                default: begin
                    if (r_phase != PH_HASHES && w_class.is_prefix) begin
                        p_raw   = 1'b1;
                        p_phase = PH_HASHES;
                    end else if (w_class.is_hash) begin
                        if (r_hash_goal >= HW'(rsl_pkg::MAX_HASHES)) begin
                            p_tail_en     = 1'b1;
                            p_tail_status = rsl_pkg::ST_TOO_MANY;
                            p_clear       = 1'b1;
                        end else begin
                            p_goal  = r_hash_goal + {{(HW-1){1'b0}}, 1'b1};
                            p_phase = PH_HASHES;
                        end
                    end else if (w_class.is_quote) begin
                        p_phase = PH_BODY;
                        p_seen  = '0;
                    end else begin
                        p_tail_en     = 1'b1;
                        p_tail_status = rsl_pkg::ST_NO_OPEN;
                        p_clear       = 1'b1;
                    end
                end
            endcase
        end
        if (p_clear) begin
            p_phase = PH_IDLE;
            p_raw   = 1'b0;
            p_goal  = '0;
            p_seen  = '0;
        end
    end

    // Next state: accept a word, then emit its results one per free slot
    always_comb begin
        n_phase        = r_phase;
        n_raw_mode     = r_raw_mode;
        n_hash_goal    = r_hash_goal;
        n_hash_seen    = r_hash_seen;
        n_seq          = r_seq;
        n_cnt          = r_cnt;
        n_tail_en      = r_tail_en;
        n_tail_chr     = r_tail_chr;
        n_tail_byte    = r_tail_byte;
        n_tail_status  = r_tail_status;
        n_o_valid      = r_o_valid && !i_ready;
        n_o_char       = r_o_char;
        n_o_char_valid = r_o_char_valid;
        n_o_status     = r_o_status;
        n_o_last       = r_o_last;

        case (r_seq)
            SQ_IDLE: begin
                if (w_accept) begin
                    n_phase       = p_phase;
                    n_raw_mode    = p_raw;
                    n_hash_goal   = p_goal;
                    n_hash_seen   = p_seen;
                    n_cnt         = r_hash_seen;
                    n_tail_en     = p_tail_en;
                    n_tail_chr    = p_tail_chr;
                    n_tail_byte   = p_tail_byte;
                    n_tail_status = p_tail_status;
                    if (p_flush) begin
                        n_seq = SQ_QUOTE;
                    end else if (p_tail_en) begin
                        n_seq = SQ_TAIL;
                    end
                end
            end
            SQ_QUOTE: begin
                if (w_slot_free) begin
                    n_o_valid      = 1'b1;
                    n_o_char       = rsl_pkg::CH_QUOTE;
                    n_o_char_valid = 1'b1;
                    n_o_status     = rsl_pkg::ST_BUSY;
                    n_o_last       = (r_cnt == '0) && !r_tail_en;
                    if (r_cnt != '0) begin
                        n_seq = SQ_HASH;
                    end else if (r_tail_en) begin
                        n_seq = SQ_TAIL;
                    end else begin
                        n_seq = SQ_IDLE;
                    end
                end
            end
            SQ_HASH: begin
                if (w_slot_free) begin
                    n_o_valid      = 1'b1;
                    n_o_char       = rsl_pkg::CH_HASH;
                    n_o_char_valid = 1'b1;
                    n_o_status     = rsl_pkg::ST_BUSY;
                    n_o_last       = (r_cnt == HW'(1)) && !r_tail_en;
                    n_cnt          = r_cnt - {{(HW-1){1'b0}}, 1'b1};
                    if (r_cnt == HW'(1)) begin
                        n_seq = r_tail_en ? SQ_TAIL : SQ_IDLE;
                    end
                end
            end
            SQ_TAIL: begin
                if (w_slot_free) begin
                    n_o_valid      = 1'b1;
                    n_o_char       = r_tail_chr ? r_tail_byte : 8'h00;
                    n_o_char_valid = r_tail_chr;
                    n_o_status     = r_tail_status;
                    n_o_last       = 1'b1;
                    n_seq          = SQ_IDLE;
                end
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    // State and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_raw_mode  <= 1'b0;
            r_hash_goal <= '0;
            r_hash_seen <= '0;
            r_seq       <= SQ_IDLE;
            r_cnt       <= '0;
            r_tail_en   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_raw_mode  <= n_raw_mode;
            r_hash_goal <= n_hash_goal;
            r_hash_seen <= n_hash_seen;
            r_seq       <= n_seq;
            r_cnt       <= n_cnt;
            r_tail_en   <= n_tail_en;
            r_o_valid   <= n_o_valid;
        end
        r_tail_chr     <= n_tail_chr;
        r_tail_byte    <= n_tail_byte;
        r_tail_status  <= n_tail_status;
        r_o_char       <= n_o_char;
        r_o_char_valid <= n_o_char_valid;
        r_o_status     <= n_o_status;
        r_o_last       <= n_o_last;
    end

`ifndef SYNTH
    // hash emission never starts from an empty count
    a_hash_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq == SQ_HASH |-> r_cnt != '0)
        else $error("hash flush with zero count");

    // a closing match is only pending with a nonzero goal
    a_pend_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PENDING |-> (r_hash_goal != '0 && r_hash_seen < r_hash_goal))
        else $error("pending match out of range");

    // opening count never exceeds the limit
    a_goal_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hash_goal <= HW'(rsl_pkg::MAX_HASHES))
        else $error("hash goal above limit");

    // body characters are busy words, status words close the item
    a_word_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_char_valid |-> (r_o_last && r_o_status != rsl_pkg::ST_BUSY))
        else $error("status word malformed");

    // a new word is taken only when nothing is left to emit
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_seq == SQ_IDLE))
        else $error("word accepted while sequencing");
`endif

endmodule
